/* hw/rtl/isc_pkg.sv */
// Package of the interval span carver: item, result and table entry types,
// controller states and fixed field widths. No dependencies.
package isc_pkg;

    localparam int POS_W = 20;
    localparam int ID_W  = 16;
    localparam int EPS_W = 8;
    localparam int LEN_W = 19;
    localparam int CMP_W = POS_W + 2;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CARVE = 1'b1;

    localparam logic [EPS_W-1:0] EPS_RESET = 8'd20;

    typedef struct packed {
        logic                    func;
        logic                    side_valid;
        logic [LEN_W-1:0]        setback;
        logic [LEN_W-1:0]        road_length;
        logic signed [POS_W-1:0] used_start;
        logic signed [POS_W-1:0] used_end;
    } isc_in_t;

    typedef struct packed {
        logic                    seg_valid;
        logic [ID_W-1:0]         seg_id;
        logic signed [POS_W-1:0] seg_start;
        logic signed [POS_W-1:0] seg_end;
        logic                    overflow;
        logic                    last;
    } isc_out_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] start;
        logic signed [POS_W-1:0] stop;
    } isc_span_t;

    localparam int SPAN_W = $bits(isc_span_t);

    typedef struct packed {
        logic keep;
        logic cut_left;
        logic cut_right;
    } isc_eval_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CRV_RD,
        ST_CRV_EV,
        ST_CRV_WR2,
        ST_EM_RD,
        ST_EM_LD
    } isc_state_t;

endpackage

/* hw/rtl/isc_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module isc_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/isc_span_eval.sv */
// Overlap test of one stored span against the used interval with margin.
// Depends on isc_pkg.
module isc_span_eval (
    input  isc_pkg::isc_span_t                   span,
    input  logic signed [isc_pkg::POS_W-1:0]     cut_lo,
    input  logic signed [isc_pkg::POS_W-1:0]     cut_hi,
    input  logic [isc_pkg::EPS_W-1:0]            eps,
    output isc_pkg::isc_eval_t                   dec
);
    import isc_pkg::*;

    logic signed [CMP_W-1:0] s_x;
    logic signed [CMP_W-1:0] e_x;
    logic signed [CMP_W-1:0] lo_x;
    logic signed [CMP_W-1:0] hi_x;
    logic signed [CMP_W-1:0] eps_x;
    logic signed [CMP_W-1:0] s_lim;
    logic signed [CMP_W-1:0] e_lim;
    logic                    keep;

    always_comb
    begin
        s_x   = CMP_W'(span.start);
        e_x   = CMP_W'(span.stop);
        lo_x  = CMP_W'(cut_lo);
        hi_x  = CMP_W'(cut_hi);
        eps_x = $signed({{(CMP_W-EPS_W){1'b0}}, eps});
        s_lim = s_x + eps_x;
        e_lim = e_x - eps_x;
        keep  = (hi_x <= s_lim) || (lo_x >= e_lim);
        dec.keep      = keep;
        dec.cut_left  = !keep && (lo_x > s_lim);
        dec.cut_right = !keep && (hi_x < e_lim);
    end

endmodule

/* hw/rtl/interval_span_carver_core.sv */
// Top level of the interval span carver: controller, span table RAM and
// output register. Depends on isc_pkg, isc_ram and isc_span_eval.
//
// Usage:
//   req channel (req_valid/req_stall/req_item) takes one add or carve item
//   while the controller is idle. rsp channel (rsp_valid/rsp_stall/rsp_item)
//   returns the whole table after each item, one span per item in table
//   order, or one empty item when the table is empty; last marks the end.
//   cfg_we/cfg_data write margin_eps at any edge; write it only when idle.
// Operation:
//   Spans live in one RAM split in two banks of 2**AW entries, MAX_SPANS
//   rounded up to a power of two; a carve reads the live bank and rebuilds
//   into the other, then swaps banks.
//   Add: one write state, then a read and a load state per emitted span.
//   Carve: per stored span a read and an evaluate state, plus a second
//   write state when it splits, then emission as for an add.
// Reset: table empty, next id zero, margin_eps 20; no clearing pass.
// Stall: the output register holds its item while rsp_stall is high and the
//   controller waits; a new request is taken once emission has finished,
//   even while the last result still waits in the output register.
module interval_span_carver_core #(
    parameter int MAX_SPANS = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  isc_pkg::isc_in_t           req_item,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output isc_pkg::isc_out_t          rsp_item,
    input  logic                       cfg_we,
    input  logic [isc_pkg::EPS_W-1:0]  cfg_data
);
    import isc_pkg::*;

    localparam int AW        = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int CW        = $clog2(MAX_SPANS + 1);
    localparam int RAM_DEPTH = 2 * (1 << AW);
    localparam int ADD_W     = LEN_W + 2;
    localparam logic [ADD_W-1:0] HALF = ADD_W'(1) << (FRAC_BITS - 1);
    localparam logic [CW-1:0]    CAP  = CW'(MAX_SPANS);

    isc_state_t              state_reg, state_next;
    isc_in_t                 item_reg, item_next;
    logic [EPS_W-1:0]        eps_reg, eps_next;
    logic                    bank_reg, bank_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           fresh_reg, fresh_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic                    ovf_reg, ovf_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    isc_out_t                rsp_reg, rsp_next;

    logic                    ram_we;
    logic [AW:0]             ram_waddr;
    isc_span_t               ram_wspan;
    logic                    ram_re;
    logic [AW:0]             ram_raddr;
    logic [SPAN_W-1:0]       ram_rdata;
    isc_span_t               rd_span;
    isc_eval_t               dec;

    logic                    accept;
    logic                    rsp_free;
    logic                    last_idx;
    logic                    add_ok;
    logic                    first_piece;
    logic                    load;

    assign rd_span   = isc_span_t'(ram_rdata);
    assign accept    = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign last_idx  = (idx_reg + CW'(1)) == count_reg;
    assign add_ok    = item_reg.side_valid &&
                       ({2'b00, item_reg.road_length} >=
                        ({1'b0, item_reg.setback, 1'b0} + HALF));
    assign first_piece = dec.keep || dec.cut_left;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    isc_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (RAM_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wspan),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    isc_span_eval u_eval (
        .span   (rd_span),
        .cut_lo (item_reg.used_start),
        .cut_hi (item_reg.used_end),
        .eps    (eps_reg),
        .dec    (dec)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_item.func == FUNC_ADD)
                    begin
                        state_next = ST_ADD;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_EM_RD;
                    end
                    else
                    begin
                        state_next = ST_CRV_RD;
                    end
                end
            end
            ST_ADD:     state_next = ST_EM_RD;
            ST_CRV_RD:  state_next = ST_CRV_EV;
            ST_CRV_EV:
            begin
                if (dec.cut_right)
                begin
                    state_next = ST_CRV_WR2;
                end
                else
                begin
                    state_next = last_idx ? ST_EM_RD : ST_CRV_RD;
                end
            end
            ST_CRV_WR2: state_next = last_idx ? ST_EM_RD : ST_CRV_RD;
            ST_EM_RD:   state_next = ST_EM_LD;
            ST_EM_LD:
            begin
                if (rsp_free)
                begin
                    state_next = (count_reg == '0 || last_idx) ? ST_IDLE : ST_EM_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_next      = item_reg;
        eps_next       = cfg_we ? cfg_data : eps_reg;
        bank_next      = bank_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        idx_next       = idx_reg;
        id_next        = id_reg;
        ovf_next       = ovf_reg;
        rsp_next       = rsp_reg;
        load           = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = {~bank_reg, fresh_reg[AW-1:0]};
        ram_wspan      = rd_span;
        ram_re         = 1'b0;
        ram_raddr      = {bank_reg, idx_reg[AW-1:0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req_item;
                    ovf_next   = 1'b0;
                    idx_next   = '0;
                    fresh_next = '0;
                end
            end
            ST_ADD:
            begin
                ram_waddr       = {bank_reg, count_reg[AW-1:0]};
                ram_wspan.id    = id_reg;
                ram_wspan.start = POS_W'({1'b0, item_reg.setback});
                ram_wspan.stop  = POS_W'({1'b0, item_reg.road_length})
                                - POS_W'({1'b0, item_reg.setback});
                if (add_ok)
                begin
                    id_next = id_reg + ID_W'(1);
                    if (count_reg >= CAP)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ST_CRV_RD:
            begin
                ram_re = 1'b1;
            end
            ST_CRV_EV:
            begin
                if (!dec.keep)
                begin
                    ram_wspan.stop = item_reg.used_start;
                end
                if (first_piece)
                begin
                    if (fresh_reg >= CAP)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        fresh_next = fresh_reg + CW'(1);
                    end
                end
                if (!dec.cut_right)
                begin
                    idx_next = idx_reg + CW'(1);
                    if (last_idx)
                    begin
                        bank_next  = ~bank_reg;
                        count_next = fresh_next;
                        idx_next   = '0;
                    end
                end
            end
            ST_CRV_WR2:
            begin
                ram_wspan.id    = id_reg;
                ram_wspan.start = item_reg.used_end;
                id_next         = id_reg + ID_W'(1);
                if (fresh_reg >= CAP)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    fresh_next = fresh_reg + CW'(1);
                end
                idx_next = idx_reg + CW'(1);
                if (last_idx)
                begin
                    bank_next  = ~bank_reg;
                    count_next = fresh_next;
                    idx_next   = '0;
                end
            end
            ST_EM_RD:
            begin
                ram_re = (count_reg != '0);
            end
            ST_EM_LD:
            begin
                if (rsp_free)
                begin
                    load = 1'b1;
                    rsp_next.overflow = ovf_reg;
                    if (count_reg == '0)
                    begin
                        rsp_next.seg_valid = 1'b0;
                        rsp_next.seg_id    = '0;
                        rsp_next.seg_start = '0;
                        rsp_next.seg_end   = '0;
                        rsp_next.last      = 1'b1;
                    end
                    else
                    begin
                        rsp_next.seg_valid = 1'b1;
                        rsp_next.seg_id    = rd_span.id;
                        rsp_next.seg_start = rd_span.start;
                        rsp_next.seg_end   = rd_span.stop;
                        rsp_next.last      = last_idx;
                        idx_next           = last_idx ? '0 : idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase

        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            eps_reg       <= EPS_RESET;
            bank_reg      <= 1'b0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            idx_reg       <= '0;
            id_reg        <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eps_reg       <= eps_next;
            bank_reg      <= bank_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            idx_reg       <= idx_next;
            id_reg        <= id_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

`ifndef SYNTH
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CAP) && (fresh_reg <= CAP))
        else $error("span count beyond table size");

    a_carve_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == ST_CRV_EV || state_reg == ST_CRV_WR2))
        |-> (ram_waddr[AW] != bank_reg))
        else $error("carve wrote into the live bank");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load && rsp_next.last) |=> (state_reg == ST_IDLE))
        else $error("last result without return to idle");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && ram_we) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("add write without count advance");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EM_LD && !rsp_free) |=> (state_reg == ST_EM_LD))
        else $error("emission advanced while output was stalled");
`endif

endmodule

/* verif/interval_span_carver_checker.sv */
`timescale 1ns / 100ps
// Checker for interval_span_carver_core: watches the request, result and margin ports,
// keeps its own copy of the span table and compares every table dump.
// Depends on isc_pkg.
module interval_span_carver_checker #(
    parameter int MAX_SPANS = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  isc_pkg::isc_in_t          req_item,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  isc_pkg::isc_out_t         rsp_item,
    input  logic                      cfg_we,
    input  logic [isc_pkg::EPS_W-1:0] cfg_data,
    output int                        mismatches,
    output int                        awaited
);
    import isc_pkg::*;

    isc_span_t        spans [MAX_SPANS];
    isc_span_t        rebuilt [MAX_SPANS];
    int               span_cnt;
    int               rebuilt_cnt;
    bit               item_dropped;
    logic [ID_W-1:0]  id_next;
    logic [EPS_W-1:0] margin_q;
    isc_out_t         table_dump_q[$];
    int               fail_cnt = 0;
    int               pend_cnt = 0;

    assign mismatches = fail_cnt;
    assign awaited    = pend_cnt;

    function automatic void append_span(isc_span_t piece);
        if (rebuilt_cnt >= MAX_SPANS)
        begin
            item_dropped = 1'b1;
        end
        else
        begin
            rebuilt[rebuilt_cnt] = piece;
            rebuilt_cnt++;
        end
    endfunction

    task automatic update_span_table(input isc_in_t it);
        longint    s;
        longint    e;
        longint    us;
        longint    ue;
        longint    sb;
        longint    len;
        longint    eps;
        isc_span_t piece;
        isc_out_t  r;
        eps = margin_q;
        item_dropped = 1'b0;
        rebuilt_cnt = 0;
        if (it.func == FUNC_ADD)
        begin
            for (int i = 0; i < span_cnt; i++)
            begin
                rebuilt[i] = spans[i];
            end
            rebuilt_cnt = span_cnt;
            sb = it.setback;
            len = it.road_length;
            if (it.side_valid && len >= 2 * sb + (longint'(1) << (FRAC_BITS - 1)))
            begin
                piece.id = id_next;
                piece.start = POS_W'(sb);
                piece.stop = POS_W'(len - sb);
                id_next++;
                append_span(piece);
            end
        end
        else
        begin
            us = $signed(it.used_start);
            ue = $signed(it.used_end);
            for (int i = 0; i < span_cnt; i++)
            begin
                s = $signed(spans[i].start);
                e = $signed(spans[i].stop);
                if (ue <= s + eps || us >= e - eps)
                begin
                    append_span(spans[i]);
                end
                else
                begin
                    if (us > s + eps && us - s > eps)
                    begin
                        piece = spans[i];
                        piece.stop = POS_W'(us);
                        append_span(piece);
                    end
                    if (ue < e - eps)
                    begin
                        piece.id = id_next;
                        piece.start = POS_W'(ue);
                        piece.stop = spans[i].stop;
                        id_next++;
                        if (e - ue > eps)
                        begin
                            append_span(piece);
                        end
                    end
                end
            end
        end
        for (int i = 0; i < rebuilt_cnt; i++)
        begin
            spans[i] = rebuilt[i];
        end
        span_cnt = rebuilt_cnt;

        if (span_cnt == 0)
        begin
            r = '0;
            r.overflow = item_dropped;
            r.last = 1'b1;
            table_dump_q.insert(table_dump_q.size(), r);
        end
        else
        begin
            for (int i = 0; i < span_cnt; i++)
            begin
                r.seg_valid = 1'b1;
                r.seg_id = spans[i].id;
                r.seg_start = spans[i].start;
                r.seg_end = spans[i].stop;
                r.overflow = item_dropped;
                r.last = (i == span_cnt - 1);
                table_dump_q.insert(table_dump_q.size(), r);
            end
        end
    endtask

    function automatic void check_field(string fname, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", fname, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        isc_out_t want;
        if (!rst_n)
        begin
            span_cnt = 0;
            id_next = '0;
            margin_q = EPS_RESET;
            table_dump_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                margin_q = cfg_data;
            end
            if (req_valid && !req_stall)
            begin
                update_span_table(req_item);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (table_dump_q.size() == 0)
                begin
                    $error("result with no item pending: id %0d start %0d end %0d",
                           rsp_item.seg_id, rsp_item.seg_start, rsp_item.seg_end);
                    fail_cnt++;
                end
                else
                begin
                    want = table_dump_q[0];
                    table_dump_q.delete(0);
                    check_field("seg_valid", want.seg_valid, rsp_item.seg_valid);
                    check_field("seg_id", want.seg_id, rsp_item.seg_id);
                    check_field("seg_start", want.seg_start, rsp_item.seg_start);
                    check_field("seg_end", want.seg_end, rsp_item.seg_end);
                    check_field("overflow", want.overflow, rsp_item.overflow);
                    check_field("last", want.last, rsp_item.last);
                end
            end
        end
        pend_cnt = table_dump_q.size();
    end

endmodule

/* verif/interval_span_carver_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for interval_span_carver_core: clock, reset, add and carve items,
// margin writes, random request gaps and random result stalls.
// Depends on isc_pkg, interval_span_carver_core and interval_span_carver_checker.
module interval_span_carver_core_tb;
    import isc_pkg::*;

    localparam int MAX_SPANS = 16;
    localparam int FRAC_BITS = 8;
    localparam int N_PHASES  = 5;
    localparam int PHASE_LEN = 80;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    isc_in_t          req_item;
    logic             rsp_valid;
    logic             rsp_stall;
    isc_out_t         rsp_item;
    logic             cfg_we;
    logic [EPS_W-1:0] cfg_data;
    int               mismatches;
    int               awaited;
    bit               tx_calm;
    bit               rx_calm;

    logic [EPS_W-1:0] margin_plan [N_PHASES] = '{8'd0, 8'd255, 8'd1, 8'd20, 8'd0};
    int               add_pct [N_PHASES] = '{60, 50, 65, 45, 55};

    interval_span_carver_core #(
        .MAX_SPANS (MAX_SPANS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    interval_span_carver_checker #(
        .MAX_SPANS (MAX_SPANS),
        .FRAC_BITS (FRAC_BITS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic isc_in_t make_add(bit sv, int sb, int len);
        isc_in_t it;
        it.func = FUNC_ADD;
        it.side_valid = sv;
        it.setback = LEN_W'(sb);
        it.road_length = LEN_W'(len);
        it.used_start = POS_W'($urandom);
        it.used_end = POS_W'($urandom);
        return it;
    endfunction

    function automatic isc_in_t make_carve(int us, int ue);
        isc_in_t it;
        it.func = FUNC_CARVE;
        it.side_valid = 1'($urandom);
        it.setback = LEN_W'($urandom);
        it.road_length = LEN_W'($urandom);
        it.used_start = POS_W'(us);
        it.used_end = POS_W'(ue);
        return it;
    endfunction

    function automatic isc_in_t random_add();
        int r;
        int sb;
        r = $urandom_range(0, 99);
        sb = $urandom_range(0, 600);
        if (r < 80)
            return make_add(1'b1, sb, 2 * sb + 128 + $urandom_range(0, 6000));
        else if (r < 86)
            return make_add(1'b0, sb, 2 * sb + 128 + $urandom_range(0, 6000));
        else if (r < 90)
            return make_add(1'b1, sb, 2 * sb + 127);
        else if (r < 95)
            return make_add(1'b1, $urandom_range(0, 1000), (1 << LEN_W) - 1);
        else
            return make_add(1'($urandom), $urandom, $urandom);
    endfunction

    function automatic isc_in_t random_carve();
        int r;
        int us;
        int ue;
        r = $urandom_range(0, 99);
        us = $urandom_range(0, 8200) - 200;
        ue = us + $urandom_range(0, 1500);
        if (r < 75)
            return make_carve(us, ue);
        else if (r < 85)
            return make_carve(ue, us);
        else if (r < 95)
            return make_carve($urandom, $urandom);
        else
            return make_carve(-(1 << (POS_W - 1)), (1 << (POS_W - 1)) - 1);
    endfunction

    task automatic send_item(input isc_in_t it);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item <= it;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (awaited != 0) @(negedge clk);
    endtask

    task automatic set_margin(input logic [EPS_W-1:0] eps);
        drain();
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= eps;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver: random stall bursts, with calm stretches
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        rx_calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 12)) @(negedge clk);
            if ($urandom_range(0, 19) == 0)
                rx_calm = !rx_calm;
            n = rx_calm ? 0 : pick_gap();
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        tx_calm = 1'b0;
        margin_plan[3] = EPS_W'($urandom_range(2, 254));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at the reset margin
        send_item(make_carve(-100, 100));
        send_item(make_add(1'b0, 100, 4000));
        send_item(make_add(1'b1, 1000, 2127));
        send_item(make_add(1'b1, 1000, 2128));
        send_item(make_add(1'b1, 0, (1 << LEN_W) - 1));
        send_item(make_carve(2000, 3000));
        send_item(make_carve(5000, 4000));
        send_item(make_add(1'b1, (1 << LEN_W) - 1, (1 << LEN_W) - 1));
        for (int k = 1; k <= 13; k++)
        begin
            send_item(make_add(1'b1, 16 * k, 3000 + 64 * k));
        end
        send_item(make_carve(500, 600));
        send_item(make_carve(-(1 << (POS_W - 1)), (1 << (POS_W - 1)) - 1));

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_margin(margin_plan[p]);
            repeat (PHASE_LEN)
            begin
                if ($urandom_range(0, 99) < add_pct[p])
                    send_item(random_add());
                else
                    send_item(random_carve());
            end
        end

        drain();
        repeat (80) @(negedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
